// ===== design/lobm_pkg.sv =====
// Package for the limit order book matcher: field widths, opcodes, status codes,
// controller states and the book cell command/status structs. No dependencies.
package lobm_pkg;

    localparam int unsigned DefaultOrdersPerSide = 32;
    localparam int unsigned ValW = 32;

    typedef enum logic [1:0] {
        OP_LIMIT  = 2'd0,
        OP_MARKET = 2'd1,
        OP_CANCEL = 2'd2,
        OP_RSVD   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_RESTED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_TRADE,
        S_CANCEL,
        S_REST,
        S_FINAL
    } ctrl_state_t;

    // Command to one book, applied to every cell of the chain at once.
    typedef struct packed {
        logic              pop;     // remove the head entry, shift the row up
        logic              dec;     // reduce the head quantity by dec_qty
        logic [ValW-1:0]   dec_qty;
        logic              ins;     // insert a new entry at its sorted place
        logic              del;     // remove the first entry whose id matches
        logic [ValW-1:0]   id;
        logic [ValW-1:0]   price;
        logic [ValW-1:0]   qty;
    } book_cmd_t;

    // Status reported by one book to the controller.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic              hit;     // some valid entry carries the command id
        logic [ValW-1:0]   head_id;
        logic [ValW-1:0]   head_price;
        logic [ValW-1:0]   head_qty;
    } book_stat_t;

endpackage

// ===== design/lobm_cell.sv =====
// One cell of a sorted book chain: holds one resting order and takes its next
// value from itself, from either neighbour or from the command. Depends on lobm_pkg.
module lobm_cell #(
    parameter bit IS_BID = 1'b1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lobm_pkg::book_cmd_t        cmd,
    // Neighbour towards the head (better priority).
    input  logic                       up_valid,
    input  logic                       up_ins_here, // upstream cell or earlier takes insert
    input  logic                       up_del_seen, // match already found at or above up
    input  logic [lobm_pkg::ValW-1:0]  up_id,
    input  logic [lobm_pkg::ValW-1:0]  up_price,
    input  logic [lobm_pkg::ValW-1:0]  up_qty,
    // Neighbour towards the tail.
    input  logic                       dn_valid,
    input  logic [lobm_pkg::ValW-1:0]  dn_id,
    input  logic [lobm_pkg::ValW-1:0]  dn_price,
    input  logic [lobm_pkg::ValW-1:0]  dn_qty,
    input  logic                       is_head,
    output logic                       valid,
    output logic                       ins_here,
    output logic                       del_seen,
    output logic [lobm_pkg::ValW-1:0]  id,
    output logic [lobm_pkg::ValW-1:0]  price,
    output logic [lobm_pkg::ValW-1:0]  qty
);

    logic                      valid_reg, valid_next;
    logic [lobm_pkg::ValW-1:0] id_reg, id_next;
    logic [lobm_pkg::ValW-1:0] price_reg, price_next;
    logic [lobm_pkg::ValW-1:0] qty_reg, qty_next;
    logic                      goes_after;
    logic                      place_ins;
    logic                      match_here;

    assign valid = valid_reg;
    assign id    = id_reg;
    assign price = price_reg;
    assign qty   = qty_reg;

    // A new order goes behind this entry while the entry's price is at least as good.
    assign goes_after = valid_reg &&
                        (IS_BID ? (price_reg >= cmd.price) : (price_reg <= cmd.price));
    assign place_ins  = !goes_after;
    assign ins_here   = up_ins_here || place_ins;
    assign match_here = valid_reg && (id_reg == cmd.id);
    assign del_seen   = up_del_seen || match_here;

    // Shift up on removal, shift down or load on insert, decrement the head, else hold.
    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        priority if (cmd.pop || (cmd.del && del_seen)) begin
            valid_next = dn_valid;
            id_next    = dn_id;
            price_next = dn_price;
            qty_next   = dn_qty;
        end else if (cmd.ins && up_ins_here) begin
            valid_next = up_valid;
            id_next    = up_id;
            price_next = up_price;
            qty_next   = up_qty;
        end else if (cmd.ins && place_ins) begin
            valid_next = 1'b1;
            id_next    = cmd.id;
            price_next = cmd.price;
            qty_next   = cmd.qty;
        end else if (cmd.dec && is_head) begin
            qty_next   = qty_reg - cmd.dec_qty;
        end else begin
            // Nothing addresses this cell, so it keeps its entry.
        end
    end

    // Occupancy is control state; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg    <= id_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

// ===== design/lobm_book.sv =====
// One side of the book as a chain of lobm_cell instances, best order at the
// head. Depends on lobm_pkg and lobm_cell.
module lobm_book #(
    parameter int unsigned DEPTH  = lobm_pkg::DefaultOrdersPerSide,
    parameter bit          IS_BID = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lobm_pkg::book_cmd_t  cmd,
    output lobm_pkg::book_stat_t stat
);

    logic [DEPTH-1:0]          c_valid, c_ins, c_del;
    logic [lobm_pkg::ValW-1:0] c_id    [DEPTH];
    logic [lobm_pkg::ValW-1:0] c_price [DEPTH];
    logic [lobm_pkg::ValW-1:0] c_qty   [DEPTH];

    // The chain: each cell sees its two neighbours, ends tied off.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            lobm_cell #(.IS_BID(IS_BID)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
                .up_valid(1'b0), .up_ins_here(1'b0), .up_del_seen(1'b0),
                .up_id('0), .up_price('0), .up_qty('0),
                .dn_valid(c_valid[1]), .dn_id(c_id[1]),
                .dn_price(c_price[1]), .dn_qty(c_qty[1]),
                .is_head(1'b1),
                .valid(c_valid[0]), .ins_here(c_ins[0]), .del_seen(c_del[0]),
                .id(c_id[0]), .price(c_price[0]), .qty(c_qty[0])
            );
        end else if (g == DEPTH - 1) begin : g_tail
            lobm_cell #(.IS_BID(IS_BID)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
                .up_valid(c_valid[g-1]), .up_ins_here(c_ins[g-1]),
                .up_del_seen(c_del[g-1]),
                .up_id(c_id[g-1]), .up_price(c_price[g-1]), .up_qty(c_qty[g-1]),
                .dn_valid(1'b0), .dn_id('0), .dn_price('0), .dn_qty('0),
                .is_head(1'b0),
                .valid(c_valid[g]), .ins_here(c_ins[g]), .del_seen(c_del[g]),
                .id(c_id[g]), .price(c_price[g]), .qty(c_qty[g])
            );
        end else begin : g_mid
            lobm_cell #(.IS_BID(IS_BID)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
                .up_valid(c_valid[g-1]), .up_ins_here(c_ins[g-1]),
                .up_del_seen(c_del[g-1]),
                .up_id(c_id[g-1]), .up_price(c_price[g-1]), .up_qty(c_qty[g-1]),
                .dn_valid(c_valid[g+1]), .dn_id(c_id[g+1]),
                .dn_price(c_price[g+1]), .dn_qty(c_qty[g+1]),
                .is_head(1'b0),
                .valid(c_valid[g]), .ins_here(c_ins[g]), .del_seen(c_del[g]),
                .id(c_id[g]), .price(c_price[g]), .qty(c_qty[g])
            );
        end
    end

    // Status towards the controller.
    assign stat.empty      = !c_valid[0];
    assign stat.full       = c_valid[DEPTH-1];
    assign stat.hit        = c_del[DEPTH-1];
    assign stat.head_id    = c_id[0];
    assign stat.head_price = c_price[0];
    assign stat.head_qty   = c_qty[0];

    // Occupied cells always form a prefix of the chain.
    for (genvar a = 1; a < DEPTH; a++) begin : g_chk
        a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
            c_valid[a] |-> c_valid[a-1])
            else $error("book holds a gap at cell %0d", a);
    end

    a_no_ins_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |-> !c_valid[DEPTH-1])
        else $error("insert issued into a full book");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop || cmd.dec) |-> c_valid[0])
        else $error("head update on an empty book");

endmodule

// ===== design/limit_order_book_matcher.sv =====
// Limit order book matcher top level: input register, controller and the
// bid and ask cell chains. Depends on lobm_pkg, lobm_book and lobm_cell.
//
// Each side of the book is a chain of ORDERS_PER_SIDE cells sorted by price and
// arrival, best order at the head. An item is loaded, then each trade is a compare
// against the opposite head followed by a step in which the trade result is
// offered and the head cell updated when it is taken; a final compare (or, for a
// cancel, the cancel itself), the resting of any remainder and the completion
// result follow, the sequence being set by the single head cell that every trade
// reads and writes. Results are driven from the working registers and the book
// heads and stay stable until taken; a new item is taken once the completion
// result has left.
module limit_order_book_matcher #(
    parameter int unsigned ORDERS_PER_SIDE = lobm_pkg::DefaultOrdersPerSide
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // opcode[1:0], side[2], oid[34:3], price[66:35], quantity[98:67], zeros
    input  logic [103:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // buy_order_id[31:0], sell_order_id[63:32], exec_price[95:64],
    // exec_qty[127:96], status[130:128], best_bid[162:131],
    // best_bid_valid[163], best_ask[195:164], best_ask_valid[196], zeros
    output logic [199:0]  m_tdata,
    // kind
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int unsigned W = lobm_pkg::ValW;

    lobm_pkg::ctrl_state_t state_reg, state_next;
    lobm_pkg::opcode_t     op_reg, op_next;
    logic                  side_reg, side_next;
    logic [W-1:0]          id_reg, id_next, price_reg, price_next, rem_reg, rem_next;
    lobm_pkg::status_t     st_reg, st_next;
    logic [W-1:0]          tq_reg, tq_next;

    lobm_pkg::book_cmd_t   bid_cmd, ask_cmd;
    lobm_pkg::book_stat_t  bid_stat, ask_stat;
    lobm_pkg::book_stat_t  opp_stat, own_stat;
    logic                  buy, crosses, xfer_out;
    logic [W-1:0]          fill_qty;

    lobm_book #(.DEPTH(ORDERS_PER_SIDE), .IS_BID(1'b1)) u_bid (
        .aclk(aclk), .aresetn(aresetn), .cmd(bid_cmd), .stat(bid_stat));
    lobm_book #(.DEPTH(ORDERS_PER_SIDE), .IS_BID(1'b0)) u_ask (
        .aclk(aclk), .aresetn(aresetn), .cmd(ask_cmd), .stat(ask_stat));

    assign buy      = !side_reg;
    assign opp_stat = buy ? ask_stat : bid_stat;
    assign own_stat = buy ? bid_stat : ask_stat;
    assign crosses  = (op_reg == lobm_pkg::OP_MARKET) ||
                      (buy ? (price_reg >= opp_stat.head_price)
                           : (price_reg <= opp_stat.head_price));
    assign fill_qty = (rem_reg < opp_stat.head_qty) ? rem_reg : opp_stat.head_qty;
    assign xfer_out = m_tvalid && m_tready;

    // Output fields come straight from the registers and the book heads.
    assign s_tready = (state_reg == lobm_pkg::S_IDLE);
    assign m_tvalid = (state_reg == lobm_pkg::S_TRADE) || (state_reg == lobm_pkg::S_FINAL);
    assign m_tuser  = (state_reg == lobm_pkg::S_FINAL);
    assign m_tlast  = (state_reg == lobm_pkg::S_FINAL);
    always_comb begin
        m_tdata = '0;
        if (state_reg == lobm_pkg::S_TRADE) begin
            m_tdata[31:0]   = buy ? id_reg : opp_stat.head_id;
            m_tdata[63:32]  = buy ? opp_stat.head_id : id_reg;
            m_tdata[95:64]  = opp_stat.head_price;
            m_tdata[127:96] = tq_reg;
        end else if (state_reg == lobm_pkg::S_FINAL) begin
            m_tdata[130:128] = st_reg;
            m_tdata[162:131] = bid_stat.empty ? '0 : bid_stat.head_price;
            m_tdata[163]     = !bid_stat.empty;
            m_tdata[195:164] = ask_stat.empty ? '0 : ask_stat.head_price;
            m_tdata[196]     = !ask_stat.empty;
        end
    end

    // Controller: next state, working registers and book commands.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        side_next  = side_reg;
        id_next    = id_reg;
        price_next = price_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        tq_next    = tq_reg;
        bid_cmd    = '0;
        ask_cmd    = '0;
        bid_cmd.id = id_reg;    bid_cmd.price = price_reg;    bid_cmd.qty = rem_reg;
        ask_cmd.id = id_reg;    ask_cmd.price = price_reg;    ask_cmd.qty = rem_reg;
        bid_cmd.dec_qty = tq_reg;
        ask_cmd.dec_qty = tq_reg;
        unique case (state_reg)
            lobm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = lobm_pkg::opcode_t'(s_tdata[1:0]);
                    side_next  = s_tdata[2];
                    id_next    = s_tdata[34:3];
                    price_next = s_tdata[66:35];
                    rem_next   = s_tdata[98:67];
                    st_next    = lobm_pkg::ST_DONE;
                    unique case (lobm_pkg::opcode_t'(s_tdata[1:0]))
                        lobm_pkg::OP_CANCEL: state_next = lobm_pkg::S_CANCEL;
                        lobm_pkg::OP_RSVD:   state_next = lobm_pkg::S_FINAL;
                        default:             state_next = lobm_pkg::S_MATCH;
                    endcase
                end
            end
            lobm_pkg::S_MATCH: begin
                priority if (rem_reg != '0 && !opp_stat.empty && crosses) begin
                    tq_next    = fill_qty;
                    state_next = lobm_pkg::S_TRADE;
                end else if (rem_reg == '0) begin
                    state_next = lobm_pkg::S_FINAL;
                end else if (op_reg == lobm_pkg::OP_MARKET) begin
                    st_next    = lobm_pkg::ST_DROPPED;
                    state_next = lobm_pkg::S_FINAL;
                end else if (own_stat.full) begin
                    st_next    = lobm_pkg::ST_FULL;
                    state_next = lobm_pkg::S_FINAL;
                end else begin
                    state_next = lobm_pkg::S_REST;
                end
            end
            lobm_pkg::S_TRADE: begin
                if (xfer_out) begin
                    rem_next = rem_reg - tq_reg;
                    if (buy) begin
                        ask_cmd.pop = (opp_stat.head_qty == tq_reg);
                        ask_cmd.dec = 1'b1;
                    end else begin
                        bid_cmd.pop = (opp_stat.head_qty == tq_reg);
                        bid_cmd.dec = 1'b1;
                    end
                    state_next = lobm_pkg::S_MATCH;
                end
            end
            lobm_pkg::S_CANCEL: begin
                // Bid book has precedence over the ask book.
                priority if (bid_stat.hit) begin
                    bid_cmd.del = 1'b1;
                    st_next     = lobm_pkg::ST_CANCELLED;
                end else if (ask_stat.hit) begin
                    ask_cmd.del = 1'b1;
                    st_next     = lobm_pkg::ST_CANCELLED;
                end else begin
                    st_next     = lobm_pkg::ST_NOTFOUND;
                end
                state_next = lobm_pkg::S_FINAL;
            end
            lobm_pkg::S_REST: begin
                if (buy) begin
                    bid_cmd.ins = 1'b1;
                end else begin
                    ask_cmd.ins = 1'b1;
                end
                st_next    = lobm_pkg::ST_RESTED;
                state_next = lobm_pkg::S_FINAL;
            end
            lobm_pkg::S_FINAL: begin
                if (xfer_out) begin
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            default: state_next = lobm_pkg::S_IDLE;
        endcase
    end

    // State register and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lobm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg    <= op_next;
        side_reg  <= side_next;
        id_reg    <= id_next;
        price_reg <= price_next;
        rem_reg   <= rem_next;
        st_reg    <= st_next;
        tq_reg    <= tq_next;
    end

    a_trade_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lobm_pkg::S_TRADE) |-> (tq_reg != '0))
        else $error("trade of zero quantity");

    a_trade_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lobm_pkg::S_TRADE) |-> (tq_reg <= rem_reg))
        else $error("trade exceeds remaining quantity");

    a_final_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer_out && m_tlast) |=> (state_reg == lobm_pkg::S_IDLE))
        else $error("controller busy after completion transfer");

endmodule
